// ===== rtl/tfs_pkg.sv =====
`default_nettype none

package tfs_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int DIV_STEPS = 31;

	localparam logic [2:0] REG_MAX_ACCEL = 3'd0;
	localparam logic [2:0] REG_MAX_DECEL = 3'd1;
	localparam logic [2:0] REG_MAX_SPEED = 3'd2;
	localparam logic [2:0] REG_MAX_LAT   = 3'd3;
	localparam logic [2:0] REG_TRACTION  = 3'd4;
	localparam logic [2:0] REG_DRAG      = 3'd5;

	localparam logic [30:0] REG_RESET = 31'd65536;

	localparam logic signed [31:0] K_SPIN = -32'sd6554;
	localparam logic signed [31:0] K_DRAG = -32'sd16384;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;
	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	typedef struct packed {
		logic [30:0] amax;
		logic [30:0] dmax;
		logic [30:0] vmax;
		logic [30:0] lmax;
		logic [30:0] tg;
		logic [30:0] dg;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] c;
		logic signed [15:0] s;
		logic signed [31:0] sf;
		logic signed [31:0] sl;
		logic signed [31:0] w;
		logic signed [31:0] a;
		logic [30:0] m;
		logic [30:0] inr;
		logic [30:0] dt;
	} item_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic signed [15:0] c;
		logic signed [15:0] s;
		logic [30:0] dt;
		logic signed [31:0] lat;
		logic signed [31:0] spin;
		logic signed [31:0] dragx;
		logic signed [31:0] dragy;
		logic signed [31:0] drvx;
		logic signed [31:0] drvy;
	} d1_pay_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic signed [15:0] c;
		logic signed [15:0] s;
		logic signed [31:0] spin;
		logic signed [31:0] dragx;
		logic signed [31:0] dragy;
		logic signed [31:0] drvx;
		logic signed [31:0] drvy;
	} d2_pay_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > SAT_HI) begin
			return S32_MAX;
		end else if (v < SAT_LO) begin
			return S32_MIN;
		end
		return v[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/tfs_front.sv =====
`default_nettype none

module tfs_front import tfs_pkg::*; (
	input  wire logic signed [15:0] heading_cos,
	input  wire logic signed [15:0] heading_sin,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] spin_rate,
	input  wire logic [30:0]        body_mass,
	input  wire logic [30:0]        body_inertia,
	input  wire logic signed [31:0] accel_request,
	input  wire logic [30:0]        time_step,
	input  wire logic [30:0]        amax,
	input  wire logic [30:0]        dmax,
	output item_t                   item
);

	logic signed [48:0] dot_f;
	logic signed [48:0] dot_r;
	logic signed [31:0] a_lim;
	logic signed [31:0] a_hi;
	logic signed [31:0] a_lo;

	// forward and lateral speed
	assign dot_f = heading_cos * vel_x + heading_sin * vel_y;
	assign dot_r = heading_cos * vel_y - heading_sin * vel_x;
	assign a_hi = $signed({1'b0, amax});
	assign a_lo = -$signed({1'b0, dmax});

	always_comb begin
		a_lim = accel_request;
		if (a_lim > a_hi) begin
			a_lim = a_hi;
		end
		if (a_lim < a_lo) begin
			a_lim = a_lo;
		end
	end

	always_comb begin
		item.c = heading_cos;
		item.s = heading_sin;
		item.sf = sat32(66'(dot_f >>> 14));
		item.sl = sat32(66'(dot_r >>> 14));
		item.w = spin_rate;
		item.a = a_lim;
		item.m = body_mass;
		item.inr = body_inertia;
		item.dt = time_step;
	end

endmodule

`default_nettype wire

// ===== rtl/tfs_fifo.sv =====
`default_nettype none

module tfs_fifo import tfs_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  item_t     push_data,
	output logic      full,
	input  wire logic pop,
	output item_t     pop_data,
	output logic      empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	item_t           mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tfs_div.sv =====
`default_nettype none

module tfs_div import tfs_pkg::*; #(
	parameter int PW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [30:0]   in_den,
	input  wire logic [30:0]   in_hi,
	input  wire logic [30:0]   in_lo,
	input  wire logic [PW-1:0] in_pay,
	output logic               out_valid,
	output logic [30:0]        out_quo,
	output logic               out_rem_nz,
	output logic [PW-1:0]      out_pay
);

	logic          v_s   [DIV_STEPS];
	logic [30:0]   rem_s [DIV_STEPS];
	logic [30:0]   quo_s [DIV_STEPS];
	logic [30:0]   lo_s  [DIV_STEPS];
	logic [30:0]   den_s [DIV_STEPS];
	logic [PW-1:0] pay_s [DIV_STEPS];

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic          vp;
		logic [30:0]   remp;
		logic [30:0]   quop;
		logic [30:0]   lop;
		logic [30:0]   denp;
		logic [PW-1:0] payp;
		logic [31:0]   trial;
		logic [32:0]   diff;

		if (k == 0) begin : g_first
			assign vp = in_valid;
			assign remp = in_hi;
			assign quop = '0;
			assign lop = in_lo;
			assign denp = in_den;
			assign payp = in_pay;
		end else begin : g_next
			assign vp = v_s[k-1];
			assign remp = rem_s[k-1];
			assign quop = quo_s[k-1];
			assign lop = lo_s[k-1];
			assign denp = den_s[k-1];
			assign payp = pay_s[k-1];
		end

		assign trial = {remp, lop[30]};
		assign diff = {1'b0, trial} - {2'b0, denp};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= diff[32] ? trial[30:0] : diff[30:0];
				quo_s[k] <= {quop[29:0], ~diff[32]};
				lo_s[k] <= {lop[29:0], 1'b0};
				den_s[k] <= denp;
				pay_s[k] <= payp;
			end
		end
	end

	assign out_valid = v_s[DIV_STEPS-1];
	assign out_quo = quo_s[DIV_STEPS-1];
	assign out_rem_nz = |rem_s[DIV_STEPS-1];
	assign out_pay = pay_s[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/tfs_back.sv =====
`default_nettype none

module tfs_back import tfs_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  cfg_t              cfg,
	input  wire logic         in_valid,
	input  item_t             in_item,
	output logic              in_take,
	output logic              res_valid,
	input  wire logic         res_pop,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] spin_impulse
);

	localparam int D1W = $bits(d1_pay_t);
	localparam int D2W = $bits(d2_pay_t);

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, res_valid_q;

	logic [61:0]        tiP_s1, tdP_s1;
	logic signed [63:0] dmP_s1, ltP_s1, nP_s1;
	logic signed [31:0] w_s1, sf_s1;
	logic signed [15:0] c_s1, s_s1, c_s2, s_s2, c_s3, s_s3, c_s4, s_s4, c_s5, s_s5;
	logic [30:0]        dt_s1, dt_s2, dt_s3, dt_s4, dt_s5;

	logic signed [31:0] ti, td, lt;
	logic signed [63:0] spinP_s2, dmagP_s2, nP_s2, nP_s3, nP_s4, nP_s5;
	logic signed [31:0] dmg_s2, lat_s2, lat_s3, lat_s4, lat_s5;

	logic signed [63:0] spinQ_s3, dmagQ_s3, drvxP_s3, drvyP_s3;
	logic signed [31:0] spin_s4, dmag_s4, drvx_s4, drvy_s4;
	logic signed [63:0] dragxP_s5, dragyP_s5;
	logic signed [31:0] spin_s5, drvx_s5, drvy_s5;

	logic [30:0] vmax_eff;
	d1_pay_t     d1_in, d1_out;
	logic [D1W-1:0] d1_out_raw;
	logic        d1_valid;
	logic [30:0] q1;

	logic signed [31:0] half, avail, avail_neg, lat_lim;
	d1_pay_t     p_nxt;
	d1_pay_t     p_s6;

	logic [31:0] mag;
	logic [30:0] dt_eff;
	d2_pay_t     d2_in, d2_out;
	logic [D2W-1:0] d2_out_raw;
	logic        d2_valid;
	logic [30:0] q2;
	logic        rnz2;

	logic signed [32:0] lf_neg;
	logic signed [31:0] lf;
	logic signed [16:0] ns;
	logic signed [63:0] latxP_s7, latyP_s7;
	logic signed [31:0] drvx_s7, drvy_s7, dragx_s7, dragy_s7, spin_s7;
	logic signed [31:0] fsx_s8, fsy_s8, dragx_s8, dragy_s8, spin_s8;
	logic signed [63:0] gxP_s9, gyP_s9;
	logic signed [31:0] dragx_s9, dragy_s9, spin_s9;
	logic signed [31:0] force_x_q, force_y_q, spin_q;

	assign adv = !res_valid_q || res_pop;
	assign in_take = adv && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= d1_valid;
			v_s7 <= d2_valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			res_valid_q <= v_s9;
		end
	end

	// saturate the first products
	assign ti = sat32(66'($signed({1'b0, tiP_s1 >> 16})));
	assign td = sat32(66'($signed({1'b0, tdP_s1 >> 16})));
	assign lt = sat32(66'(ltP_s1 >>> 16));

	// products and scaled terms ahead of the speed division
	always_ff @(posedge clk) begin
		if (adv) begin
			tiP_s1 <= cfg.tg * in_item.inr;
			tdP_s1 <= cfg.tg * cfg.dg;
			dmP_s1 <= $signed({1'b0, in_item.m}) * $signed(in_item.a);
			ltP_s1 <= $signed({1'b0, in_item.m}) * $signed(in_item.sl);
			nP_s1 <= $signed({1'b0, cfg.lmax}) * $signed(in_item.sf);
			w_s1 <= in_item.w;
			sf_s1 <= in_item.sf;
			c_s1 <= in_item.c;
			s_s1 <= in_item.s;
			dt_s1 <= in_item.dt;

			spinP_s2 <= ti * w_s1;
			dmagP_s2 <= td * sf_s1;
			dmg_s2 <= sat32(66'(dmP_s1 >>> 15));
			lat_s2 <= sat32(-66'(lt));
			nP_s2 <= nP_s1;
			c_s2 <= c_s1;
			s_s2 <= s_s1;
			dt_s2 <= dt_s1;

			spinQ_s3 <= sat32(66'(spinP_s2 >>> 16)) * K_SPIN;
			dmagQ_s3 <= sat32(66'(dmagP_s2 >>> 16)) * K_DRAG;
			drvxP_s3 <= dmg_s2 * c_s2;
			drvyP_s3 <= dmg_s2 * s_s2;
			lat_s3 <= lat_s2;
			nP_s3 <= nP_s2;
			c_s3 <= c_s2;
			s_s3 <= s_s2;
			dt_s3 <= dt_s2;

			spin_s4 <= sat32(66'(spinQ_s3 >>> 16));
			dmag_s4 <= sat32(66'(dmagQ_s3 >>> 16));
			drvx_s4 <= sat32(66'(drvxP_s3 >>> 14));
			drvy_s4 <= sat32(66'(drvyP_s3 >>> 14));
			lat_s4 <= lat_s3;
			nP_s4 <= nP_s3;
			c_s4 <= c_s3;
			s_s4 <= s_s3;
			dt_s4 <= dt_s3;

			dragxP_s5 <= dmag_s4 * c_s4;
			dragyP_s5 <= dmag_s4 * s_s4;
			spin_s5 <= spin_s4;
			drvx_s5 <= drvx_s4;
			drvy_s5 <= drvy_s4;
			lat_s5 <= lat_s4;
			nP_s5 <= nP_s4;
			c_s5 <= c_s4;
			s_s5 <= s_s4;
			dt_s5 <= dt_s4;
		end
	end

	// available impulse: floor(L*sf / max_speed)
	assign vmax_eff = (cfg.vmax == '0) ? 31'd1 : cfg.vmax;

	always_comb begin
		d1_in.neg = nP_s5[63];
		d1_in.ovf = (nP_s5[61:31] >= vmax_eff);
		d1_in.c = c_s5;
		d1_in.s = s_s5;
		d1_in.dt = dt_s5;
		d1_in.lat = lat_s5;
		d1_in.spin = spin_s5;
		d1_in.dragx = sat32(66'(dragxP_s5 >>> 14));
		d1_in.dragy = sat32(66'(dragyP_s5 >>> 14));
		d1_in.drvx = drvx_s5;
		d1_in.drvy = drvy_s5;
	end

	tfs_div #(.PW(D1W)) u_div_avail (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (v_s5),
		.in_den     (vmax_eff),
		.in_hi      (nP_s5[61:31]),
		.in_lo      (nP_s5[30:0]),
		.in_pay     (d1_in),
		.out_valid  (d1_valid),
		.out_quo    (q1),
		.out_rem_nz (),
		.out_pay    (d1_out_raw)
	);

	assign d1_out = d1_pay_t'(d1_out_raw);
	assign half = $signed({2'b0, cfg.lmax[30:1]});

	// negative quotients always lose to the half limit
	always_comb begin
		if (d1_out.neg) begin
			avail = half;
		end else if (d1_out.ovf) begin
			avail = S32_MAX;
		end else begin
			avail = $signed({1'b0, q1});
		end
		if (avail < half) begin
			avail = half;
		end
		avail_neg = -avail;
		lat_lim = d1_out.lat;
		if (lat_lim > avail) begin
			lat_lim = avail;
		end else if (lat_lim < avail_neg) begin
			lat_lim = avail_neg;
		end
		p_nxt = d1_out;
		p_nxt.lat = lat_lim;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s6 <= p_nxt;
		end
	end

	// lateral force: floor(lat * 65536 / dt)
	assign mag = p_s6.lat[31] ? -p_s6.lat : p_s6.lat;
	assign dt_eff = (p_s6.dt == '0) ? 31'd1 : p_s6.dt;

	always_comb begin
		d2_in.neg = p_s6.lat[31];
		d2_in.ovf = ({15'b0, mag[30:15]} >= dt_eff);
		d2_in.c = p_s6.c;
		d2_in.s = p_s6.s;
		d2_in.spin = p_s6.spin;
		d2_in.dragx = p_s6.dragx;
		d2_in.dragy = p_s6.dragy;
		d2_in.drvx = p_s6.drvx;
		d2_in.drvy = p_s6.drvy;
	end

	tfs_div #(.PW(D2W)) u_div_lat (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (v_s6),
		.in_den     (dt_eff),
		.in_hi      ({15'b0, mag[30:15]}),
		.in_lo      ({mag[14:0], 16'b0}),
		.in_pay     (d2_in),
		.out_valid  (d2_valid),
		.out_quo    (q2),
		.out_rem_nz (rnz2),
		.out_pay    (d2_out_raw)
	);

	assign d2_out = d2_pay_t'(d2_out_raw);
	assign lf_neg = -$signed({2'b0, q2}) - $signed({32'b0, rnz2});

	always_comb begin
		if (d2_out.neg) begin
			lf = d2_out.ovf ? S32_MIN : lf_neg[31:0];
		end else begin
			lf = d2_out.ovf ? S32_MAX : $signed({1'b0, q2});
		end
	end

	assign ns = -$signed({d2_out.s[15], d2_out.s});

	// combine lateral, drive, traction and drag
	always_ff @(posedge clk) begin
		if (adv) begin
			latxP_s7 <= lf * ns;
			latyP_s7 <= lf * d2_out.c;
			drvx_s7 <= d2_out.drvx;
			drvy_s7 <= d2_out.drvy;
			dragx_s7 <= d2_out.dragx;
			dragy_s7 <= d2_out.dragy;
			spin_s7 <= d2_out.spin;

			fsx_s8 <= sat32(66'(sat32(66'(latxP_s7 >>> 14))) + 66'(drvx_s7));
			fsy_s8 <= sat32(66'(sat32(66'(latyP_s7 >>> 14))) + 66'(drvy_s7));
			dragx_s8 <= dragx_s7;
			dragy_s8 <= dragy_s7;
			spin_s8 <= spin_s7;

			gxP_s9 <= $signed({1'b0, cfg.tg}) * fsx_s8;
			gyP_s9 <= $signed({1'b0, cfg.tg}) * fsy_s8;
			dragx_s9 <= dragx_s8;
			dragy_s9 <= dragy_s8;
			spin_s9 <= spin_s8;

			force_x_q <= sat32(66'(sat32(66'(gxP_s9 >>> 16))) + 66'(dragx_s9));
			force_y_q <= sat32(66'(sat32(66'(gyP_s9 >>> 16))) + 66'(dragy_s9));
			spin_q <= spin_s9;
		end
	end

	assign res_valid = res_valid_q;
	assign force_x = force_x_q;
	assign force_y = force_y_q;
	assign spin_impulse = spin_q;

endmodule

`default_nettype wire

// ===== rtl/tire_force_step.sv =====
`default_nettype none

// channel   direction  handshake                 payload
// input     in         push / full               heading, velocity, spin, mass, inertia, accel, step
// result    out        empty / pop               force_x, force_y, spin_impulse
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one transfer per cycle on each side, sustained while each result is popped as it shows
// the back pipeline holds the two 31-stage pipelined dividers, speed limit then lateral force
// no clearing after reset; the input queue accepts at once
// a pending result holds the whole back pipeline; the input queue absorbs up to its depth

module tire_force_step import tfs_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] heading_cos,
	input  wire logic signed [15:0] heading_sin,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] spin_rate,
	input  wire logic [30:0]        body_mass,
	input  wire logic [30:0]        body_inertia,
	input  wire logic signed [31:0] accel_request,
	input  wire logic [30:0]        time_step,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      force_x,
	output logic signed [31:0]      force_y,
	output logic signed [31:0]      spin_impulse,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	cfg_t  cfg_q;
	item_t fe_item;
	item_t q_item;
	logic  q_push;
	logic  q_pop;
	logic  q_empty;
	logic  res_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amax <= REG_RESET;
			cfg_q.dmax <= REG_RESET;
			cfg_q.vmax <= REG_RESET;
			cfg_q.lmax <= REG_RESET;
			cfg_q.tg <= REG_RESET;
			cfg_q.dg <= REG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_ACCEL: cfg_q.amax <= cfg_data[30:0];
				REG_MAX_DECEL: cfg_q.dmax <= cfg_data[30:0];
				REG_MAX_SPEED: cfg_q.vmax <= cfg_data[30:0];
				REG_MAX_LAT:   cfg_q.lmax <= cfg_data[30:0];
				REG_TRACTION:  cfg_q.tg <= cfg_data[30:0];
				REG_DRAG:      cfg_q.dg <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	tfs_front u_front (
		.heading_cos   (heading_cos),
		.heading_sin   (heading_sin),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.spin_rate     (spin_rate),
		.body_mass     (body_mass),
		.body_inertia  (body_inertia),
		.accel_request (accel_request),
		.time_step     (time_step),
		.amax          (cfg_q.amax),
		.dmax          (cfg_q.dmax),
		.item          (fe_item)
	);

	assign q_push = push && !full;

	tfs_fifo #(.DEPTH(QUEUE_DEPTH_P)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (fe_item),
		.full      (full),
		.pop       (q_pop),
		.pop_data  (q_item),
		.empty     (q_empty)
	);

	tfs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (!q_empty),
		.in_item      (q_item),
		.in_take      (q_pop),
		.res_valid    (res_valid),
		.res_pop      (pop),
		.force_x      (force_x),
		.force_y      (force_y),
		.spin_impulse (spin_impulse)
	);

	assign empty = !res_valid;

	a_queue_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue read while empty");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !pop) |=> (res_valid && $stable(force_x) && $stable(force_y)
			&& $stable(spin_impulse)))
		else $error("pending result changed before its transfer");

endmodule

`default_nettype wire
